/* src/sbq_pkg.sv */
// shared types and constants for the stereo biquad high-pass block
// no dependencies; used by sbq_front, sbq_back and the top level
package sbq_pkg;

    // fixed field widths
    localparam int SBQ_SAMPLE_W = 32;
    localparam int SBQ_COEF_W = 32;
    localparam int SBQ_COEF_FRAC_BITS = 24;

    // two-entry queues on both sides
    localparam int SBQ_QDEPTH = 2;
    localparam int SBQ_QPTR_W = 1;
    localparam int SBQ_QCNT_W = 2;

    // configuration register indexes
    localparam int SBQ_CFG_IDX_W = 3;
    localparam logic [SBQ_CFG_IDX_W-1:0] SBQ_REG_B0 = 3'd0;
    localparam logic [SBQ_CFG_IDX_W-1:0] SBQ_REG_B1 = 3'd1;
    localparam logic [SBQ_CFG_IDX_W-1:0] SBQ_REG_B2 = 3'd2;
    localparam logic [SBQ_CFG_IDX_W-1:0] SBQ_REG_A1 = 3'd3;
    localparam logic [SBQ_CFG_IDX_W-1:0] SBQ_REG_A2 = 3'd4;
    localparam logic [SBQ_CFG_IDX_W-1:0] SBQ_REG_EN = 3'd5;

    // one classified stereo frame
    typedef struct packed {
        logic signed [SBQ_SAMPLE_W-1:0] left;
        logic signed [SBQ_SAMPLE_W-1:0] right;
        logic                           last;
        logic                           filt;
    } t_frame;

    // section coefficients
    typedef struct packed {
        logic signed [SBQ_COEF_W-1:0] b0;
        logic signed [SBQ_COEF_W-1:0] b1;
        logic signed [SBQ_COEF_W-1:0] b2;
        logic signed [SBQ_COEF_W-1:0] a1;
        logic signed [SBQ_COEF_W-1:0] a2;
    } t_coefs;

endpackage

/* src/sbq_front.sv */
// front end: accepts stereo frames, tags them as filter or bypass, queues them
// depends on sbq_pkg
module sbq_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_push,
    output logic                                     o_full,
    input  logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0]  i_sample_left,
    input  logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0]  i_sample_right,
    input  logic                                     i_frame_last,
    input  logic                                     i_filter_en,
    output logic                                     o_valid,
    output sbq_pkg::t_frame                          o_frame,
    input  logic                                     i_take
);

    sbq_pkg::t_frame r_mem [sbq_pkg::SBQ_QDEPTH];
    logic [sbq_pkg::SBQ_QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [sbq_pkg::SBQ_QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [sbq_pkg::SBQ_QCNT_W-1:0] r_count, n_count;
    logic                           wr_ok;
    logic                           rd_ok;
    sbq_pkg::t_frame                frame_in;

    // classify the incoming frame
    always_comb begin
        frame_in.left  = i_sample_left;
        frame_in.right = i_sample_right;
        frame_in.last  = i_frame_last;
        frame_in.filt  = i_filter_en;
    end

    // handshake flags
    assign o_full  = (r_count == sbq_pkg::SBQ_QCNT_W'(sbq_pkg::SBQ_QDEPTH));
    assign o_valid = (r_count != '0);
    assign wr_ok   = i_push && !o_full;
    assign rd_ok   = i_take && o_valid;
    assign o_frame = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + sbq_pkg::SBQ_QPTR_W'(wr_ok);
        n_rd_ptr = r_rd_ptr + sbq_pkg::SBQ_QPTR_W'(rd_ok);
        n_count  = r_count + sbq_pkg::SBQ_QCNT_W'(wr_ok) - sbq_pkg::SBQ_QCNT_W'(rd_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= frame_in;
        end
    end

endmodule

/* src/sbq_back.sv */
// back end: runs both channels through the biquad with five multipliers,
// keeps the per-channel history and queues finished results; depends on sbq_pkg
module sbq_back #(
    parameter int COEF_FRAC_BITS = sbq_pkg::SBQ_COEF_FRAC_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  sbq_pkg::t_coefs                          i_coefs,
    input  logic                                     i_clear,
    input  logic                                     i_valid,
    input  sbq_pkg::t_frame                          i_frame,
    output logic                                     o_take,
    output logic                                     o_empty,
    input  logic                                     i_pop,
    output logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0]  o_filtered_left,
    output logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0]  o_filtered_right,
    output logic                                     o_out_last
);

    localparam int SW = sbq_pkg::SBQ_SAMPLE_W;
    localparam int PW = 2 * SW;

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_L = 3'd1;
    localparam logic [2:0] ST_SUM_L = 3'd2;
    localparam logic [2:0] ST_MUL_R = 3'd3;
    localparam logic [2:0] ST_SUM_R = 3'd4;
    localparam logic [2:0] ST_PASS  = 3'd5;

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 last;
    } t_result;

    logic [2:0]            r_state, n_state;
    sbq_pkg::t_frame       r_cur;
    logic signed [SW-1:0]  r_x1 [2];
    logic signed [SW-1:0]  r_x2 [2];
    logic signed [SW-1:0]  r_y1 [2];
    logic signed [SW-1:0]  r_y2 [2];
    logic [SW-1:0]         r_p0, r_p1, r_p2, r_p3, r_p4;
    logic signed [SW-1:0]  r_yl;

    logic                  ch;
    logic signed [SW-1:0]  mul_x;
    logic signed [PW-1:0]  prod0, prod1, prod2, prod3, prod4;
    logic [SW-1:0]         y_sum;
    logic                  is_mul;
    logic                  is_sum;
    logic                  finish;
    logic                  take;
    t_result               res_in;

    t_result                         r_out [sbq_pkg::SBQ_QDEPTH];
    logic [sbq_pkg::SBQ_QPTR_W-1:0]  r_owr_ptr;
    logic [sbq_pkg::SBQ_QPTR_W-1:0]  r_ord_ptr;
    logic [sbq_pkg::SBQ_QCNT_W-1:0]  r_ocount;
    logic [sbq_pkg::SBQ_QCNT_W-1:0]  ocount_next;
    logic                            pop_ok;

    // channel and step decode
    assign ch     = (r_state == ST_MUL_R) || (r_state == ST_SUM_R);
    assign is_mul = (r_state == ST_MUL_L) || (r_state == ST_MUL_R);
    assign is_sum = (r_state == ST_SUM_L) || (r_state == ST_SUM_R);
    assign finish = (r_state == ST_SUM_R) || (r_state == ST_PASS);
    assign mul_x  = ch ? r_cur.right : r_cur.left;

    // five tap products of the current channel
    assign prod0 = PW'(i_coefs.b0) * PW'(mul_x);
    assign prod1 = PW'(i_coefs.b1) * PW'(r_x1[ch]);
    assign prod2 = PW'(i_coefs.b2) * PW'(r_x2[ch]);
    assign prod3 = PW'(i_coefs.a1) * PW'(r_y1[ch]);
    assign prod4 = PW'(i_coefs.a2) * PW'(r_y2[ch]);

    // only the low word of each shifted product reaches the wrapped sum
    always_ff @(posedge i_clk) begin
        if (is_mul) begin
            r_p0 <= prod0[COEF_FRAC_BITS +: SW];
            r_p1 <= prod1[COEF_FRAC_BITS +: SW];
            r_p2 <= prod2[COEF_FRAC_BITS +: SW];
            r_p3 <= prod3[COEF_FRAC_BITS +: SW];
            r_p4 <= prod4[COEF_FRAC_BITS +: SW];
        end
    end

    assign y_sum = r_p0 + r_p1 + r_p2 - r_p3 - r_p4;

    // result queue occupancy and the room check for the next request
    assign pop_ok      = i_pop && !o_empty;
    assign ocount_next = r_ocount + sbq_pkg::SBQ_QCNT_W'(finish)
                         - sbq_pkg::SBQ_QCNT_W'(pop_ok);
    assign take   = i_valid && ((r_state == ST_IDLE) || finish)
                    && (ocount_next != sbq_pkg::SBQ_QCNT_W'(sbq_pkg::SBQ_QDEPTH));
    assign o_take = take;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_MUL_L: n_state = ST_SUM_L;
            ST_SUM_L: n_state = ST_MUL_R;
            ST_MUL_R: n_state = ST_SUM_R;
            ST_IDLE, ST_SUM_R, ST_PASS: begin
                if (take) begin
                    n_state = i_frame.filt ? ST_MUL_L : ST_PASS;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // current frame and left result
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur <= i_frame;
        end
        if (r_state == ST_SUM_L) begin
            r_yl <= y_sum;
        end
    end

    // channel history, cleared by any coefficient write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int c = 0; c < 2; c++) begin
                r_x1[c] <= '0;
                r_x2[c] <= '0;
                r_y1[c] <= '0;
                r_y2[c] <= '0;
            end
        end else if (is_sum) begin
            r_x2[ch] <= r_x1[ch];
            r_x1[ch] <= mul_x;
            r_y2[ch] <= r_y1[ch];
            r_y1[ch] <= y_sum;
        end
    end

    // result to be queued
    always_comb begin
        if (r_state == ST_PASS) begin
            res_in.left  = r_cur.left;
            res_in.right = r_cur.right;
        end else begin
            res_in.left  = r_yl;
            res_in.right = y_sum;
        end
        res_in.last = r_cur.last;
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr_ptr <= '0;
            r_ord_ptr <= '0;
            r_ocount  <= '0;
        end else begin
            r_owr_ptr <= r_owr_ptr + sbq_pkg::SBQ_QPTR_W'(finish);
            r_ord_ptr <= r_ord_ptr + sbq_pkg::SBQ_QPTR_W'(pop_ok);
            r_ocount  <= ocount_next;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out[r_owr_ptr] <= res_in;
        end
    end

    assign o_empty          = (r_ocount == '0);
    assign o_filtered_left  = r_out[r_ord_ptr].left;
    assign o_filtered_right = r_out[r_ord_ptr].right;
    assign o_out_last       = r_out[r_ord_ptr].last;

endmodule

/* src/stereo_biquad_highpass_q24.sv */
// stereo biquad section, q24 coefficients, direct form 1, queue ports both sides
// a filtered frame runs left then right through five shared multipliers, a
// multiply step and a sum step per channel; a bypassed frame goes through the
// pass state; a new request is taken as the last one finishes if the result
// queue has room, so bypassed frames go at one per cycle while it has room
// reset: queues empty, history zero, coefficients zero, filter enabled
module stereo_biquad_highpass_q24 #(
    parameter int COEF_FRAC_BITS = sbq_pkg::SBQ_COEF_FRAC_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      push,
    output logic                                      full,
    input  logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0]   i_sample_left,
    input  logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0]   i_sample_right,
    input  logic                                      i_frame_last,
    output logic                                      empty,
    input  logic                                      pop,
    output logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0]   o_filtered_left,
    output logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0]   o_filtered_right,
    output logic                                      o_out_last,
    input  logic                                      i_cfg_we,
    input  logic [sbq_pkg::SBQ_CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [sbq_pkg::SBQ_COEF_W-1:0]            i_cfg_data
);

    sbq_pkg::t_coefs r_coefs;
    logic            r_filter_en;
    logic            cfg_clear;
    logic            fe_valid;
    logic            fe_take;
    sbq_pkg::t_frame fe_frame;

    // configuration registers; any coefficient write clears the history
    assign cfg_clear = i_cfg_we && (i_cfg_idx == sbq_pkg::SBQ_REG_B0
                                 || i_cfg_idx == sbq_pkg::SBQ_REG_B1
                                 || i_cfg_idx == sbq_pkg::SBQ_REG_B2
                                 || i_cfg_idx == sbq_pkg::SBQ_REG_A1
                                 || i_cfg_idx == sbq_pkg::SBQ_REG_A2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs     <= '0;
            r_filter_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbq_pkg::SBQ_REG_B0: r_coefs.b0  <= i_cfg_data;
                sbq_pkg::SBQ_REG_B1: r_coefs.b1  <= i_cfg_data;
                sbq_pkg::SBQ_REG_B2: r_coefs.b2  <= i_cfg_data;
                sbq_pkg::SBQ_REG_A1: r_coefs.a1  <= i_cfg_data;
                sbq_pkg::SBQ_REG_A2: r_coefs.a2  <= i_cfg_data;
                sbq_pkg::SBQ_REG_EN: r_filter_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front end with request queue
    sbq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_sample_left  (i_sample_left),
        .i_sample_right (i_sample_right),
        .i_frame_last   (i_frame_last),
        .i_filter_en    (r_filter_en),
        .o_valid        (fe_valid),
        .o_frame        (fe_frame),
        .i_take         (fe_take)
    );

    // filter engine with result queue
    sbq_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_coefs          (r_coefs),
        .i_clear          (cfg_clear),
        .i_valid          (fe_valid),
        .i_frame          (fe_frame),
        .o_take           (fe_take),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_filtered_left  (o_filtered_left),
        .o_filtered_right (o_filtered_right),
        .o_out_last       (o_out_last)
    );

endmodule

/* verif/testbench.sv */
// self-checking bench for stereo_biquad_highpass_q24: directed table, then randomised phases
// holds its own q24 biquad predictor and a queue of expected frames; depends on sbq_pkg and the top level
`timescale 1ns / 1ps

module testbench;

    localparam int ITEMS_PER_PHASE = 190;
    localparam int PHASES = 8;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_TAIL = 8;
    localparam int TABLE_ROWS = 25;

    // spare register indexes, writes there must be ignored
    localparam logic [sbq_pkg::SBQ_CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [sbq_pkg::SBQ_CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [31:0] Q24_ONE = 32'h0100_0000;
    localparam logic [31:0] Q24_MINUS_ONE = 32'hFF00_0000;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] left;
        logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] right;
        logic                                    last;
    } t_result;

    typedef enum logic [1:0] {ROW_WRITE, ROW_FRAME, ROW_FRAME_TYPED} t_row_kind;

    typedef struct packed {
        t_row_kind                         kind;
        logic [sbq_pkg::SBQ_CFG_IDX_W-1:0] idx;
        logic [31:0]                       data;
        logic [31:0]                       left;
        logic [31:0]                       right;
        logic                              last;
        logic [31:0]                       want_left;
        logic [31:0]                       want_right;
    } t_row;

    logic                                    i_clk;
    logic                                    i_rst_n;
    logic                                    push;
    logic                                    full;
    logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] i_sample_left;
    logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] i_sample_right;
    logic                                    i_frame_last;
    logic                                    empty;
    logic                                    pop;
    logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] o_filtered_left;
    logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] o_filtered_right;
    logic                                    o_out_last;
    logic                                    i_cfg_we;
    logic [sbq_pkg::SBQ_CFG_IDX_W-1:0]       i_cfg_idx;
    logic [sbq_pkg::SBQ_COEF_W-1:0]          i_cfg_data;

    stereo_biquad_highpass_q24 dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_sample_left    (i_sample_left),
        .i_sample_right   (i_sample_right),
        .i_frame_last     (i_frame_last),
        .empty            (empty),
        .pop              (pop),
        .o_filtered_left  (o_filtered_left),
        .o_filtered_right (o_filtered_right),
        .o_out_last       (o_out_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // predictor copy of coefficients, enable and per-channel history
    sbq_pkg::t_coefs                         coefs;
    logic                                    filt_on;
    logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] hist_x1 [2];
    logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] hist_x2 [2];
    logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] hist_y1 [2];
    logic signed [sbq_pkg::SBQ_SAMPLE_W-1:0] hist_y2 [2];

    t_result frames_due [$];
    int      mismatch_count = 0;
    int      stall_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    // directed stimulus; typed rows carry results readable at a glance
    t_row stim_table [TABLE_ROWS] = '{
        '{ROW_FRAME_TYPED, sbq_pkg::SBQ_REG_B0, 32'd0, S32_MAX, S32_MIN, 1'b1,
          32'd0, 32'd0},
        '{ROW_FRAME_TYPED, sbq_pkg::SBQ_REG_B0, 32'd0, 32'h1234_5678, ALL_ONES, 1'b0,
          32'd0, 32'd0},
        '{ROW_WRITE, sbq_pkg::SBQ_REG_EN, 32'h0000_0002, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_FRAME_TYPED, sbq_pkg::SBQ_REG_B0, 32'd0, S32_MAX, S32_MIN, 1'b1,
          S32_MAX, S32_MIN},
        '{ROW_FRAME_TYPED, sbq_pkg::SBQ_REG_B0, 32'd0, ALL_ONES, 32'd0, 1'b0,
          ALL_ONES, 32'd0},
        '{ROW_WRITE, sbq_pkg::SBQ_REG_EN, ALL_ONES, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE, sbq_pkg::SBQ_REG_B0, Q24_ONE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_FRAME_TYPED, sbq_pkg::SBQ_REG_B0, 32'd0, 32'd100, -32'sd100, 1'b0,
          32'd100, -32'sd100},
        '{ROW_FRAME_TYPED, sbq_pkg::SBQ_REG_B0, 32'd0, S32_MIN, S32_MAX, 1'b1,
          S32_MIN, S32_MAX},
        '{ROW_WRITE, sbq_pkg::SBQ_REG_B1, Q24_ONE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_FRAME, sbq_pkg::SBQ_REG_B0, 32'd0, 32'd7, 32'd5, 1'b0, 32'd0, 32'd0},
        '{ROW_FRAME, sbq_pkg::SBQ_REG_B0, 32'd0, S32_MAX, S32_MAX, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE, sbq_pkg::SBQ_REG_B2, Q24_MINUS_ONE, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE, sbq_pkg::SBQ_REG_A1, S32_MIN, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE, sbq_pkg::SBQ_REG_A2, S32_MAX, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_FRAME, sbq_pkg::SBQ_REG_B0, 32'd0, S32_MIN, S32_MIN, 1'b1, 32'd0, 32'd0},
        '{ROW_FRAME, sbq_pkg::SBQ_REG_B0, 32'd0, S32_MAX, ALL_ONES, 1'b0, 32'd0, 32'd0},
        '{ROW_FRAME, sbq_pkg::SBQ_REG_B0, 32'd0, 32'd1, 32'h5555_5555, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE, sbq_pkg::SBQ_REG_EN, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_FRAME_TYPED, sbq_pkg::SBQ_REG_B0, 32'd0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
          32'hAAAA_AAAA, 32'h5555_5555},
        '{ROW_WRITE, REG_SPARE_LO, ALL_ONES, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE, REG_SPARE_HI, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE, sbq_pkg::SBQ_REG_EN, 32'd1, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
        '{ROW_FRAME, sbq_pkg::SBQ_REG_B0, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0},
        '{ROW_FRAME, sbq_pkg::SBQ_REG_B0, 32'd0, ALL_ONES, 32'd1, 1'b0, 32'd0, 32'd0}
    };

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // full 64-bit product, arithmetic shift down to the sample scale
    function automatic longint q_product(logic signed [31:0] c, logic signed [31:0] x);
        longint p;
        p = longint'(c) * longint'(x);
        return p >>> sbq_pkg::SBQ_COEF_FRAC_BITS;
    endfunction

    // one channel through the section, history advanced
    function automatic logic signed [31:0] section_out(int ch, logic signed [31:0] x);
        longint                acc;
        logic signed [31:0]    y;
        acc = q_product(coefs.b0, x) + q_product(coefs.b1, hist_x1[ch])
            + q_product(coefs.b2, hist_x2[ch]) - q_product(coefs.a1, hist_y1[ch])
            - q_product(coefs.a2, hist_y2[ch]);
        y = acc[31:0];
        hist_x2[ch] = hist_x1[ch];
        hist_x1[ch] = x;
        hist_y2[ch] = hist_y1[ch];
        hist_y1[ch] = y;
        return y;
    endfunction

    // expected frame for one request, bypass leaves history alone
    function automatic t_result filter_frame(logic [31:0] l, logic [31:0] r, logic last);
        t_result res;
        res.left = l;
        res.right = r;
        res.last = last;
        if (filt_on) begin
            res.left = section_out(0, l);
            res.right = section_out(1, r);
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return S32_MIN;
            1: return S32_MAX;
            2: return 32'd0;
            3: return $urandom;
            default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S32_MIN;
            1: return S32_MAX;
            2: return 32'd0;
            3: return ALL_ONES;
            4: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    // one request on the input side; entered and left at a falling edge
    task automatic send_frame(logic [31:0] l, logic [31:0] r, logic last,
                              logic typed, logic [31:0] want_l, logic [31:0] want_r);
        t_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_sample_left <= l;
        i_sample_right <= r;
        i_frame_last <= last;
        do @(posedge i_clk); while (full);
        res = filter_frame(l, r, last);
        if (typed) begin
            res.left = want_l;
            res.right = want_r;
        end
        frames_due.push_back(res);
        @(negedge i_clk);
    endtask

    // hold the sender until every expected frame has come out
    task automatic wait_drained();
        push <= 1'b0;
        while (frames_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    // register write, mirrored into the predictor
    task automatic write_reg(logic [sbq_pkg::SBQ_CFG_IDX_W-1:0] idx, logic [31:0] data);
        logic wipe;
        wipe = 1'b1;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            sbq_pkg::SBQ_REG_B0: coefs.b0 = data;
            sbq_pkg::SBQ_REG_B1: coefs.b1 = data;
            sbq_pkg::SBQ_REG_B2: coefs.b2 = data;
            sbq_pkg::SBQ_REG_A1: coefs.a1 = data;
            sbq_pkg::SBQ_REG_A2: coefs.a2 = data;
            sbq_pkg::SBQ_REG_EN: begin
                filt_on = data[0];
                wipe = 1'b0;
            end
            default: wipe = 1'b0;
        endcase
        if (wipe) begin
            for (int ch = 0; ch < 2; ch++) begin
                hist_x1[ch] = '0;
                hist_x2[ch] = '0;
                hist_y1[ch] = '0;
                hist_y2[ch] = '0;
            end
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // receiver side: pop with random stalls
    always @(negedge i_clk) begin
        pop <= !($urandom_range(0, 99) < recv_stall_pct);
    end

    // result check against the oldest expected frame, plus watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (frames_due.size() == 0) begin
                $error("result with no frame waiting: left %0d right %0d last %0b",
                       o_filtered_left, o_filtered_right, o_out_last);
                mismatch_count++;
            end else begin
                want = frames_due.pop_front();
                if (o_filtered_left !== want.left) begin
                    $error("filtered_left: expected %0d, got %0d", want.left, o_filtered_left);
                    mismatch_count++;
                end
                if (o_filtered_right !== want.right) begin
                    $error("filtered_right: expected %0d, got %0d", want.right,
                           o_filtered_right);
                    mismatch_count++;
                end
                if (o_out_last !== want.last) begin
                    $error("out_last: expected %0b, got %0b", want.last, o_out_last);
                    mismatch_count++;
                end
            end
        end
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        logic [31:0] val;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_sample_left = '0;
        i_sample_right = '0;
        i_frame_last = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        coefs = '0;
        filt_on = 1'b1;
        for (int ch = 0; ch < 2; ch++) begin
            hist_x1[ch] = '0;
            hist_x2[ch] = '0;
            hist_y1[ch] = '0;
            hist_y2[ch] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table, no idling
        for (int i = 0; i < TABLE_ROWS; i++) begin
            if (stim_table[i].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(stim_table[i].idx, stim_table[i].data);
            end else begin
                send_frame(stim_table[i].left, stim_table[i].right, stim_table[i].last,
                           stim_table[i].kind == ROW_FRAME_TYPED,
                           stim_table[i].want_left, stim_table[i].want_right);
            end
        end

        // random phases, each with fresh settings and one of four idling patterns
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int r = 0; r <= int'(sbq_pkg::SBQ_REG_A2); r++) begin
                if (phase == 0 || phase == 1 || phase == 5 || $urandom_range(0, 2) != 0) begin
                    if (phase == 1)
                        val = S32_MAX;
                    else if (phase == 5)
                        val = S32_MIN;
                    else
                        val = pick_coef();
                    write_reg(sbq_pkg::SBQ_CFG_IDX_W'(r), val);
                end
            end
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
            val = $urandom;
            val[0] = !(phase == 3 || phase == 6);
            write_reg(sbq_pkg::SBQ_REG_EN, val);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender holds off until the block has emptied
                if (phase == 1 && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_frame(pick_sample(), pick_sample(),
                           $urandom_range(0, 3) == 0, 1'b0, 32'd0, 32'd0);
            end
        end

        wait_drained();
        if (mismatch_count == 0 && frames_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* stereo_biquad_highpass_q24.f */
src/sbq_pkg.sv
src/sbq_front.sv
src/sbq_back.sv
src/stereo_biquad_highpass_q24.sv
verif/testbench.sv
